// File: hw/rtl/txc_pkg.sv
// shared types and constants for the text console writer
package txc_pkg;

  localparam int unsigned DEF_COLUMNS   = 80;
  localparam int unsigned DEF_ROWS      = 25;
  localparam int unsigned DEF_TAB_WIDTH = 4;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned LIN_W  = 11;
  localparam int unsigned TAB_CNT_W = 4;

  localparam logic [CMD_W-1:0] CMD_PUT_CHAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PUT_AT   = 2'd3;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_ATTR = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } txc_cell_t;

  localparam int unsigned CELL_W = $bits(txc_cell_t);

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;
  } txc_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_col_out;
    logic [LIN_W-1:0]  cursor_linear;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
    logic              scrolled;
  } txc_out_t;

endpackage

// File: hw/rtl/txc_ram.sv
// generic single write port, single read port ram with registered read
module txc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/text_console_writer.sv
// top level of the text console writer: command sequencer around the screen memory
//
// The screen lives in one ROWS x COLUMNS memory with one write and one read port.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells before it
// takes its first command; configuration writes are taken at any time. A command is
// taken in the idle state, and its result is written to the output register from the
// response state, which waits while an earlier result is still stalled there. Put-at,
// carriage return, newline without scroll and a read of an off-screen cell go there
// directly; an on-screen read-cell passes the read state, a printable put-char the
// glyph state, and a tab the glyph state once per space.
// A scroll moves each cell below the top row up one row through the memory one cell per
// cycle and then blanks the bottom row; clear-screen blanks every cell one at a time. The
// memory's single write port is why both go one cell at a time.
// A finished result waits in an output register, and the next command is taken while it waits.
module text_console_writer
  import txc_pkg::*;
#(
  parameter int unsigned COLUMNS   = DEF_COLUMNS,
  parameter int unsigned ROWS      = DEF_ROWS,
  parameter int unsigned TAB_WIDTH = DEF_TAB_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  txc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output txc_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CHAR_W-1:0] cfg_wdata_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned BLANK_START = (ROWS - 1) * COLUMNS;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_GLYPH  = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [TAB_CNT_W-1:0] cmod_q, cmod_d;
  logic [TAB_CNT_W-1:0] tab_q, tab_d;
  logic [CHAR_W-1:0]    attr_q;
  logic                 scr_q, scr_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]    glyph_q, glyph_d;
  logic [AW-1:0]        waddr_q, waddr_d;
  logic [CHAR_W-1:0]    rc_q, rc_d;
  logic [CHAR_W-1:0]    ra_q, ra_d;
  txc_out_t             out_q, out_d;

  logic          in_xfer;
  logic          tgt_in_range;
  logic [AW-1:0] tgt_addr;
  logic [AW-1:0] cur_addr;
  logic          col_last;
  logic          row_last;
  logic          fill_done;
  logic [TAB_CNT_W-1:0] cmod_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  txc_cell_t     ram_wdata;
  logic [AW-1:0] ram_raddr;
  txc_cell_t     ram_rdata;

  txc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tgt_in_range = ({1'b0, in_data_i.target_row} < (ROW_W + 1)'(ROWS)) &&
                        ({1'b0, in_data_i.target_col} < (COL_W + 1)'(COLUMNS));
  assign tgt_addr = AW'(in_data_i.target_row) * AW'(COLUMNS) + AW'(in_data_i.target_col);
  assign cur_addr = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign col_last = (col_q == COL_W'(COLUMNS - 1));
  assign row_last = (row_q == ROW_W'(ROWS - 1));
  assign fill_done = (cnt_q == CW'(CELLS - 1));
  assign cmod_inc = (cmod_q == TAB_CNT_W'(TAB_WIDTH - 1)) ? '0 : cmod_q + 1'b1;

  // memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[AW-1:0];
    ram_wdata = '{attr: BLANK_ATTR, chr: BLANK_CHAR};
    ram_raddr = tgt_addr;
    case (state_q)
      S_INIT, S_CLEAR, S_BLANK: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_we    = in_xfer && (in_data_i.command == CMD_PUT_AT) && tgt_in_range;
        ram_waddr = tgt_addr;
        ram_wdata = '{attr: attr_q, chr: in_data_i.char_code};
      end
      S_GLYPH: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = '{attr: attr_q, chr: glyph_q};
      end
      S_SCROLL: begin
        ram_we    = pend_q;
        ram_waddr = waddr_q;
        ram_wdata = ram_rdata;
        ram_raddr = cnt_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // command sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    col_d       = col_q;
    cmod_d      = cmod_q;
    tab_d       = tab_q;
    scr_d       = scr_q;
    pend_d      = pend_q;
    glyph_d     = glyph_q;
    waddr_d     = waddr_q;
    rc_d        = rc_q;
    ra_d        = ra_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (fill_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          scr_d   = 1'b0;
          rc_d    = '0;
          ra_d    = '0;
          tab_d   = '0;
          glyph_d = in_data_i.char_code;
          state_d = S_RESP;
          case (in_data_i.command)
            CMD_PUT_CHAR: begin
              if (in_data_i.char_code == CH_LF) begin
                col_d  = '0;
                cmod_d = '0;
                if (row_last) begin
                  scr_d   = 1'b1;
                  cnt_d   = CW'(COLUMNS);
                  pend_d  = 1'b0;
                  state_d = S_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                end
              end else if (in_data_i.char_code == CH_CR) begin
                col_d  = '0;
                cmod_d = '0;
              end else if (in_data_i.char_code == CH_TAB) begin
                glyph_d = BLANK_CHAR;
                tab_d   = TAB_CNT_W'(TAB_WIDTH) - cmod_q;
                state_d = S_GLYPH;
              end else begin
                tab_d   = TAB_CNT_W'(1);
                state_d = S_GLYPH;
              end
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_READ: begin
              if (tgt_in_range) begin
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        rc_d    = ram_rdata.chr;
        ra_d    = ram_rdata.attr;
        state_d = S_RESP;
      end
      S_GLYPH: begin
        tab_d   = tab_q - 1'b1;
        state_d = (tab_q == TAB_CNT_W'(1)) ? S_RESP : S_GLYPH;
        if (col_last) begin
          col_d  = '0;
          cmod_d = '0;
          if (row_last) begin
            scr_d   = 1'b1;
            cnt_d   = CW'(COLUMNS);
            pend_d  = 1'b0;
            state_d = S_SCROLL;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d  = col_q + 1'b1;
          cmod_d = cmod_inc;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write it back one row up on the next cycle
        if (cnt_q == CW'(CELLS)) begin
          pend_d  = 1'b0;
          cnt_d   = CW'(BLANK_START);
          state_d = S_BLANK;
        end else begin
          pend_d  = 1'b1;
          waddr_d = cnt_q[AW-1:0] - AW'(COLUMNS);
          cnt_d   = cnt_q + 1'b1;
        end
      end
      S_BLANK: begin
        cnt_d = cnt_q + 1'b1;
        if (fill_done) begin
          state_d = (tab_q != '0) ? S_GLYPH : S_RESP;
        end
      end
      S_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (fill_done) begin
          row_d   = '0;
          col_d   = '0;
          cmod_d  = '0;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.cursor_row_out = row_q;
          out_d.cursor_col_out = col_q;
          out_d.cursor_linear  = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);
          out_d.read_char      = rc_q;
          out_d.read_attr      = ra_q;
          out_d.scrolled       = scr_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cmod_q      <= '0;
      tab_q       <= '0;
      scr_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      attr_q      <= BLANK_ATTR;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cmod_q      <= cmod_d;
      tab_q       <= tab_d;
      scr_q       <= scr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    waddr_q <= waddr_d;
    rc_q    <= rc_d;
    ra_q    <= ra_d;
    out_q   <= out_d;
  end

endmodule
